/* hdl/leb_pkg.sv */
// Shared types and constants of the line edit buffer.
package leb_pkg;

  localparam int MAX_CHARS_DEF = 32;

  // Key codes
  localparam logic [7:0] KEY_BACK  = 8'd8;
  localparam logic [7:0] KEY_ENTER = 8'd13;
  localparam logic [7:0] KEY_ESC   = 8'd27;
  localparam logic [7:0] KEY_HOME  = 8'd71;
  localparam logic [7:0] KEY_LEFT  = 8'd75;
  localparam logic [7:0] KEY_RIGHT = 8'd77;
  localparam logic [7:0] KEY_END   = 8'd79;
  localparam logic [7:0] KEY_DEL   = 8'd83;
  localparam logic [7:0] PRINT_LO  = 8'd32;
  localparam logic [7:0] PRINT_HI  = 8'd126;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  // Configuration register indexes and reset values
  localparam logic [1:0] CFG_LINE_SIZE   = 2'd0;
  localparam logic [1:0] CFG_LOWEST_KEY  = 2'd1;
  localparam logic [1:0] CFG_HIGHEST_KEY = 2'd2;
  localparam logic [5:0] LINE_SIZE_RST   = 6'd11;
  localparam logic [7:0] LOWEST_KEY_RST  = 8'd32;
  localparam logic [7:0] HIGHEST_KEY_RST = 8'd126;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_EMIT_RD,
    ST_EMIT_PUT,
    ST_STATUS
  } ctrl_state_t;

  typedef enum logic [3:0] {
    KC_NONE,
    KC_LEFT,
    KC_RIGHT,
    KC_HOME,
    KC_END,
    KC_DEL,
    KC_BACK,
    KC_FINISH,
    KC_TYPE
  } key_class_t;

  typedef enum logic [1:0] {
    ACT_STATUS,
    ACT_SHIFT,
    ACT_EMIT
  } action_t;

  typedef struct packed {
    logic load_key;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic shift_end;
    logic emit_rd;
    logic put_status;
    logic put_char;
  } leb_cmd_t;

  typedef struct packed {
    action_t action;
    logic    shift_more;
    logic    emit_last;
    logic    out_free;
  } leb_stat_t;

endpackage

/* hdl/leb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/leb_ctrl.sv */
// Sequencer of the line edit buffer: steps edits, tail shifts and line output.
module leb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  leb_pkg::leb_stat_t stat,
  output leb_pkg::leb_cmd_t  cmd
);

  leb_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= leb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      leb_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = leb_pkg::ST_EXEC;
      end
      leb_pkg::ST_EXEC: begin
        case (stat.action)
          leb_pkg::ACT_SHIFT: state_next = leb_pkg::ST_SHIFT_RD;
          leb_pkg::ACT_EMIT:  state_next = leb_pkg::ST_EMIT_RD;
          default:            state_next = leb_pkg::ST_STATUS;
        endcase
      end
      leb_pkg::ST_SHIFT_RD: begin
        state_next = stat.shift_more ? leb_pkg::ST_SHIFT_WR : leb_pkg::ST_STATUS;
      end
      leb_pkg::ST_SHIFT_WR: state_next = leb_pkg::ST_SHIFT_RD;
      leb_pkg::ST_EMIT_RD:  state_next = leb_pkg::ST_EMIT_PUT;
      leb_pkg::ST_EMIT_PUT: begin
        if (stat.out_free) begin
          state_next = stat.emit_last ? leb_pkg::ST_IDLE : leb_pkg::ST_EMIT_RD;
        end
      end
      leb_pkg::ST_STATUS: begin
        if (stat.out_free) state_next = leb_pkg::ST_IDLE;
      end
      default: state_next = leb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      leb_pkg::ST_IDLE: begin
        s_tready     = 1'b1;
        cmd.load_key = s_tvalid;
      end
      leb_pkg::ST_EXEC:     cmd.exec = 1'b1;
      leb_pkg::ST_SHIFT_RD: begin
        cmd.shift_rd  = stat.shift_more;
        cmd.shift_end = !stat.shift_more;
      end
      leb_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      leb_pkg::ST_EMIT_RD:  cmd.emit_rd = 1'b1;
      leb_pkg::ST_EMIT_PUT: cmd.put_char = stat.out_free;
      leb_pkg::ST_STATUS:   cmd.put_status = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* hdl/leb_dp.sv */
// Datapath of the line edit buffer: registers, key decode, line store, output stage.
module leb_dp #(
  parameter int MAX_CHARS = leb_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        in_key,
  input  logic              in_ext,
  input  leb_pkg::leb_cmd_t  cmd,
  output leb_pkg::leb_stat_t stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_char,
  output logic [5:0]        out_cursor,
  output logic [5:0]        out_length,
  output logic              out_acc,
  output logic              out_last
);

  localparam int CW = $clog2(MAX_CHARS + 1);
  localparam int AW = $clog2(MAX_CHARS);

  logic [5:0]    line_size;
  logic [7:0]    lowest_key;
  logic [7:0]    highest_key;
  logic [7:0]    key;
  logic          ext;
  logic [CW-1:0] cursor;
  logic [CW-1:0] length;
  logic [CW-1:0] idx;
  logic [CW-1:0] limit;
  logic          acc;

  leb_pkg::key_class_t kc;
  logic          cur_nz;
  logic          cur_lt_len;
  logic          room;
  logic [CW:0]   idx_inc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Key decode
  always_comb begin
    kc = leb_pkg::KC_NONE;
    if (ext) begin
      case (key)
        leb_pkg::KEY_LEFT:  kc = leb_pkg::KC_LEFT;
        leb_pkg::KEY_RIGHT: kc = leb_pkg::KC_RIGHT;
        leb_pkg::KEY_HOME:  kc = leb_pkg::KC_HOME;
        leb_pkg::KEY_END:   kc = leb_pkg::KC_END;
        leb_pkg::KEY_DEL:   kc = leb_pkg::KC_DEL;
        default:            kc = leb_pkg::KC_NONE;
      endcase
    end else if (key == leb_pkg::KEY_ENTER || key == leb_pkg::KEY_ESC) begin
      kc = leb_pkg::KC_FINISH;
    end else if (key == leb_pkg::KEY_BACK) begin
      kc = leb_pkg::KC_BACK;
    end else if (key >= leb_pkg::PRINT_LO && key <= leb_pkg::PRINT_HI &&
                 key >= lowest_key && key <= highest_key) begin
      kc = leb_pkg::KC_TYPE;
    end
  end

  assign cur_nz     = (cursor != '0);
  assign cur_lt_len = (cursor < length);
  // cursor < min(line_size - 1, MAX_CHARS), with line_size zero giving no room
  assign room       = (8'(cursor) + 8'd1 < 8'(line_size)) && (8'(cursor) < 8'(MAX_CHARS));
  assign idx_inc    = {1'b0, idx} + 1'b1;

  always_comb begin
    stat.shift_more = (idx_inc < {1'b0, length});
    stat.emit_last  = (idx_inc == {1'b0, limit});
    stat.out_free   = !m_tvalid || m_tready;
    case (kc)
      leb_pkg::KC_DEL:    stat.action = cur_lt_len ? leb_pkg::ACT_SHIFT : leb_pkg::ACT_STATUS;
      leb_pkg::KC_BACK:   stat.action = cur_nz ? leb_pkg::ACT_SHIFT : leb_pkg::ACT_STATUS;
      leb_pkg::KC_FINISH: stat.action = cur_nz ? leb_pkg::ACT_EMIT : leb_pkg::ACT_STATUS;
      default:            stat.action = leb_pkg::ACT_STATUS;
    endcase
  end

  // Line store ports
  assign ram_we    = (cmd.exec && kc == leb_pkg::KC_TYPE && room) || cmd.shift_wr;
  assign ram_waddr = cmd.shift_wr ? AW'(idx) : AW'(cursor);
  assign ram_wdata = cmd.shift_wr ? ram_rdata : key;
  assign ram_re    = cmd.shift_rd || cmd.emit_rd;
  assign ram_raddr = cmd.shift_rd ? AW'(idx_inc) : AW'(idx);

  leb_ram #(
    .WIDTH(8),
    .DEPTH(MAX_CHARS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= in_key;
      ext <= in_ext;
    end
    if (cmd.exec) begin
      case (kc)
        leb_pkg::KC_LEFT:   acc <= cur_nz;
        leb_pkg::KC_RIGHT:  acc <= cur_lt_len;
        leb_pkg::KC_HOME:   acc <= cur_nz;
        leb_pkg::KC_END:    acc <= (cursor != length);
        leb_pkg::KC_DEL: begin
          acc <= cur_lt_len;
          idx <= cursor;
        end
        leb_pkg::KC_BACK: begin
          acc <= cur_nz;
          idx <= cursor - 1'b1;
        end
        leb_pkg::KC_FINISH: begin
          acc   <= 1'b1;
          idx   <= '0;
          limit <= cursor;
        end
        leb_pkg::KC_TYPE:   acc <= room;
        default:            acc <= 1'b0;
      endcase
    end
    if (cmd.shift_wr || cmd.put_char) begin
      idx <= idx + 1'b1;
    end
  end

  // Control registers and output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      line_size   <= leb_pkg::LINE_SIZE_RST;
      lowest_key  <= leb_pkg::LOWEST_KEY_RST;
      highest_key <= leb_pkg::HIGHEST_KEY_RST;
      cursor      <= '0;
      length      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          leb_pkg::CFG_LINE_SIZE:   line_size   <= cfg_data[5:0];
          leb_pkg::CFG_LOWEST_KEY:  lowest_key  <= cfg_data;
          leb_pkg::CFG_HIGHEST_KEY: highest_key <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        case (kc)
          leb_pkg::KC_LEFT:   if (cur_nz) cursor <= cursor - 1'b1;
          leb_pkg::KC_RIGHT:  if (cur_lt_len) cursor <= cursor + 1'b1;
          leb_pkg::KC_HOME:   cursor <= '0;
          leb_pkg::KC_END:    cursor <= length;
          leb_pkg::KC_BACK:   if (cur_nz) cursor <= cursor - 1'b1;
          leb_pkg::KC_FINISH: begin
            cursor <= '0;
            length <= '0;
          end
          leb_pkg::KC_TYPE: begin
            if (room) begin
              cursor <= cursor + 1'b1;
              if (cursor == length) length <= length + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.shift_end) begin
        length <= length - 1'b1;
      end
      if (cmd.put_status || cmd.put_char) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_status) begin
      out_kind <= (kc == leb_pkg::KC_FINISH) ? leb_pkg::KIND_EMPTY : leb_pkg::KIND_STATUS;
      out_char <= 8'd0;
      out_last <= 1'b1;
    end else if (cmd.put_char) begin
      out_kind <= leb_pkg::KIND_CHAR;
      out_char <= ram_rdata;
      out_last <= stat.emit_last;
    end
    if (cmd.put_status || cmd.put_char) begin
      out_cursor <= 6'(cursor);
      out_length <= 6'(length);
      out_acc    <= acc;
    end
  end

endmodule

/* hdl/line_edit_buffer.sv */
// Top level of the line edit buffer: keyboard line editor with cursor.
//
//  channel  | direction | contents
//  ---------+-----------+------------------------------------------------------
//  s_*      | in        | one key request: key code in tdata, extended flag in tuser
//  m_*      | out       | result: char, cursor, length, accepted in tdata; kind in tuser
//  cfg_*    | in        | register write: 0 line_size, 1 lowest_key, 2 highest_key
//
// Flow: one request at a time. Cursor moves, typing and refused keys step through
// accept, execute and load the output stage. An accepted Delete or Backspace adds a
// store read, then a write, for each character of the tail moved left, and a last
// read step that ends the shift. Enter/Esc put each emitted character after a
// registered store read. Reset clears cursor, length and output valid and sets the
// configuration registers to their reset values; the store itself is left as is.
// A stalled m_tready holds the result in the output stage; the next request is taken
// while the final result of the last one still waits.
module line_edit_buffer #(
  parameter int MAX_CHARS = leb_pkg::MAX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // key requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] key_code
  input  logic [0:0]  s_tuser,   // [0] is_extended
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] char_value, [13:8] cursor_pos,
                                 // [19:14] line_length, [20] accepted, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  leb_pkg::leb_cmd_t  cmd;
  leb_pkg::leb_stat_t stat;

  logic [7:0] out_char;
  logic [5:0] out_cursor;
  logic [5:0] out_length;
  logic       out_acc;

  // Sequencer: accepts a request, then walks edit, shift or emit steps
  leb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Datapath: decode, cursor/length, line store and the output register
  leb_dp #(
    .MAX_CHARS(MAX_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_key    (s_tdata),
    .in_ext    (s_tuser[0]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .out_kind  (m_tuser),
    .out_char  (out_char),
    .out_cursor(out_cursor),
    .out_length(out_length),
    .out_acc   (out_acc),
    .out_last  (m_tlast)
  );

  // Pack the result fields, lowest field first, padded to whole bytes
  assign m_tdata = {3'b000, out_acc, out_length, out_cursor, out_char};

endmodule

/* tb/line_edit_buffer_test.sv */
// Self-checking testbench of the line edit buffer: key requests against a predictor.
`timescale 1ns / 1ps

module line_edit_buffer_test;
  import leb_pkg::*;

  localparam int MAX_CHARS    = MAX_CHARS_DEF;
  // Longest request: a Delete or Backspace moving a full tail, or Enter emitting
  // a full line.
  localparam int TAIL_CYCLES  = 2 * MAX_CHARS + 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 18;

  // One result as the block reports it
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [5:0] cursor_pos;
    logic [5:0] line_length;
    logic       accepted;
    logic       last;
  } edit_result_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       is_extended;
  } key_item_t;

  // Directed row: a key, and where it can be read off at a glance, its result
  typedef struct packed {
    logic [7:0]   key_code;
    logic         is_extended;
    logic         known;
    edit_result_t want;
  } key_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_LINE_SIZE;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] key_code
  logic [0:0]  s_tuser = 1'b0;   // [0] is_extended
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [7:0] char_value, [13:8] cursor_pos,
                                 // [19:14] line_length, [20] accepted
  logic [1:0]  m_tuser;          // [1:0] kind
  logic        m_tlast;

  line_edit_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  // Predictor copy of the editor: text, cursor, length and registers
  logic [7:0] line_chars [MAX_CHARS];
  int         edit_cursor = 0;
  int         edit_length = 0;
  logic [5:0] cfg_line_size = LINE_SIZE_RST;
  logic [7:0] cfg_lowest = LOWEST_KEY_RST;
  logic [7:0] cfg_highest = HIGHEST_KEY_RST;

  edit_result_t expected_results [$];
  key_item_t    key_queue [$];
  key_row_t     key_rows [$];
  int           mismatch_count = 0;
  int           result_count = 0;
  int           cycle_count = 0;

  // Sender burst state and receiver stall pattern
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;
  int ready_phase = 0;

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("mismatch at result %0d: %s got %0d, expected %0d",
             result_count, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [7:0] ch,
                             input logic acc, input logic last);
    edit_result_t r;
    r.kind        = kind;
    r.char_value  = ch;
    r.cursor_pos  = 6'(edit_cursor);
    r.line_length = 6'(edit_length);
    r.accepted    = acc;
    r.last        = last;
    expected_results.push_back(r);
  endtask

  // Remove one character and shift the tail left
  task automatic drop_char(input int pos);
    int i;
    for (i = pos; i + 1 < edit_length; i++)
      line_chars[i] = line_chars[i + 1];
    edit_length--;
  endtask

  // Work out the results of one key and advance the predictor state
  task automatic predict_key(input logic [7:0] key, input logic ext);
    int   capacity;
    int   n;
    int   i;
    logic acc;
    acc = 1'b0;
    if (ext) begin
      case (key)
        KEY_LEFT:  if (edit_cursor > 0) begin edit_cursor--; acc = 1'b1; end
        KEY_RIGHT: if (edit_cursor < edit_length) begin edit_cursor++; acc = 1'b1; end
        KEY_HOME:  if (edit_cursor != 0) begin edit_cursor = 0; acc = 1'b1; end
        KEY_END: begin
          if (edit_cursor != edit_length) begin
            edit_cursor = edit_length;
            acc = 1'b1;
          end
        end
        KEY_DEL: begin
          if (edit_cursor < edit_length) begin
            drop_char(edit_cursor);
            acc = 1'b1;
          end
        end
        default: ;
      endcase
      push_result(KIND_STATUS, 8'd0, acc, 1'b1);
    end else if (key == KEY_ENTER || key == KEY_ESC) begin
      // Emit what stands before the cursor, drop the rest, clear the line
      n = edit_cursor;
      edit_cursor = 0;
      edit_length = 0;
      if (n == 0) begin
        push_result(KIND_EMPTY, 8'd0, 1'b1, 1'b1);
      end else begin
        for (i = 0; i < n; i++)
          push_result(KIND_CHAR, line_chars[i], 1'b1, i == n - 1);
      end
    end else begin
      if (key == KEY_BACK) begin
        if (edit_cursor > 0) begin
          edit_cursor--;
          drop_char(edit_cursor);
          acc = 1'b1;
        end
      end else if (key >= PRINT_LO && key <= PRINT_HI &&
                   key >= cfg_lowest && key <= cfg_highest) begin
        // Capacity is one less than the line size, capped at the store depth
        capacity = int'(cfg_line_size);
        if (capacity > 0) capacity--;
        if (capacity > MAX_CHARS) capacity = MAX_CHARS;
        if (edit_cursor < capacity) begin
          line_chars[edit_cursor] = key;
          if (edit_cursor == edit_length) edit_length++;
          edit_cursor++;
          acc = 1'b1;
        end
      end
      push_result(KIND_STATUS, 8'd0, acc, 1'b1);
    end
  endtask

  // Predict a key and hand it to the sender; a known row replaces the prediction
  task automatic send_key(input logic [7:0] key, input logic ext, input logic known,
                          input edit_result_t want);
    key_item_t item;
    predict_key(key, ext);
    if (known) begin
      void'(expected_results.pop_back());
      expected_results.push_back(want);
    end
    item.key_code    = key;
    item.is_extended = ext;
    key_queue.push_back(item);
  endtask

  task automatic plain_row(input logic [7:0] key, input logic ext);
    key_row_t row;
    row = '0;
    row.key_code    = key;
    row.is_extended = ext;
    key_rows.push_back(row);
  endtask

  task automatic known_row(input logic [7:0] key, input logic ext, input logic [1:0] kind,
                           input int cur, input int len, input logic acc);
    key_row_t row;
    row = '0;
    row.key_code         = key;
    row.is_extended      = ext;
    row.known            = 1'b1;
    row.want.kind        = kind;
    row.want.cursor_pos  = 6'(cur);
    row.want.line_length = 6'(len);
    row.want.accepted    = acc;
    row.want.last        = 1'b1;
    key_rows.push_back(row);
  endtask

  // Write one register while the block is idle and mirror it in the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_LINE_SIZE:   cfg_line_size = data[5:0];
      CFG_LOWEST_KEY:  cfg_lowest = data;
      CFG_HIGHEST_KEY: cfg_highest = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (key_queue.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Sender: hold each request until taken, in bursts with random gaps between
  always @(posedge clk) begin : drive_keys
    logic next_valid;
    next_valid = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        key_queue.delete(0);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (key_queue.size() > 0) begin
          s_tdata    <= key_queue[0].key_code;
          s_tuser    <= key_queue[0].is_extended;
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            // Mostly short gaps, now and then one long enough to span a whole request
            if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(10, 90);
            else gap_left = $urandom_range(0, 3);
          end
        end
      end
    end
    s_tvalid <= next_valid;
  end

  // Receiver: switch between stall patterns every so often
  always @(posedge clk) begin : drive_ready
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(20, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 1) == 1);
      2:       m_tready <= (ready_phase % 4 == 0);
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
    ready_phase++;
  end

  // Compare each taken result with the oldest expectation, field by field
  always @(posedge clk) begin : check_results
    edit_result_t got;
    edit_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind        = m_tuser;
      got.char_value  = m_tdata[7:0];
      got.cursor_pos  = m_tdata[13:8];
      got.line_length = m_tdata[19:14];
      got.accepted    = m_tdata[20];
      got.last        = m_tlast;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", got.kind, -1);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.char_value !== want.char_value)
          report_mismatch("char_value", got.char_value, want.char_value);
        if (got.cursor_pos !== want.cursor_pos)
          report_mismatch("cursor_pos", got.cursor_pos, want.cursor_pos);
        if (got.line_length !== want.line_length)
          report_mismatch("line_length", got.line_length, want.line_length);
        if (got.accepted !== want.accepted)
          report_mismatch("accepted", got.accepted, want.accepted);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
      result_count++;
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : run_test
    int         phase;
    int         k;
    int         r;
    logic [7:0] key;
    logic       ext;
    logic [7:0] key_lo;
    logic [7:0] key_hi;
    logic [5:0] size_v;
    logic [7:0] lowest_v;
    logic [7:0] highest_v;

    // Directed keys, starting from the reset settings (capacity 10, keys 32..126).
    // Keys on an empty line that move nothing; then the printable bounds are typed.
    known_row(KEY_ENTER, 1'b0, KIND_EMPTY, 0, 0, 1'b1);   // finish an empty line
    known_row(KEY_LEFT, 1'b1, KIND_STATUS, 0, 0, 1'b0);   // left at start
    known_row(KEY_RIGHT, 1'b1, KIND_STATUS, 0, 0, 1'b0);  // right at end
    known_row(KEY_BACK, 1'b0, KIND_STATUS, 0, 0, 1'b0);   // backspace at start
    known_row(KEY_DEL, 1'b1, KIND_STATUS, 0, 0, 1'b0);    // delete at end
    known_row(KEY_HOME, 1'b1, KIND_STATUS, 0, 0, 1'b0);   // home that does not move
    known_row(8'd0, 1'b0, KIND_STATUS, 0, 0, 1'b0);
    known_row(8'd255, 1'b0, KIND_STATUS, 0, 0, 1'b0);
    known_row(PRINT_LO - 8'd1, 1'b0, KIND_STATUS, 0, 0, 1'b0);
    known_row(PRINT_HI + 8'd1, 1'b0, KIND_STATUS, 0, 0, 1'b0);
    known_row(8'd72, 1'b1, KIND_STATUS, 0, 0, 1'b0);      // Up: extended, no action
    known_row(PRINT_LO, 1'b0, KIND_STATUS, 1, 1, 1'b1);   // lowest printable
    known_row(PRINT_HI, 1'b0, KIND_STATUS, 2, 2, 1'b1);   // highest printable
    // Edits in mid-line, left to the predictor
    plain_row(KEY_LEFT, 1'b0);   // same code as Left, but plain: types 'K'
    plain_row(KEY_LEFT, 1'b1);
    plain_row(KEY_HOME, 1'b1);
    plain_row(8'd66, 1'b0);      // overwrite at the start, length holds
    plain_row(KEY_END, 1'b1);
    plain_row(KEY_LEFT, 1'b1);
    plain_row(KEY_DEL, 1'b1);    // delete the last character
    plain_row(KEY_BACK, 1'b0);
    plain_row(KEY_ESC, 1'b0);    // finish with the cursor at the end of the line
    plain_row(8'd120, 1'b0);
    plain_row(8'd121, 1'b0);     // leave text in the line for the shrink below

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (key_rows[i])
      send_key(key_rows[i].key_code, key_rows[i].is_extended, key_rows[i].known,
               key_rows[i].want);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        // Zero size with text left over, and an empty key range
        0: begin size_v = 6'd0;  lowest_v = 8'd255; highest_v = 8'd0;   end
        1: begin size_v = 6'd33; lowest_v = 8'd32;  highest_v = 8'd126; end
        2: begin size_v = 6'd1;  lowest_v = 8'd0;   highest_v = 8'd255; end
        3: begin size_v = 6'd63; lowest_v = 8'd126; highest_v = 8'd126; end
        4: begin
          size_v    = 6'($urandom_range(2, 12));
          lowest_v  = 8'($urandom_range(32, 80));
          highest_v = 8'($urandom_range(60, 126));
        end
        default: begin size_v = 6'd3; lowest_v = 8'd65; highest_v = 8'd90; end
      endcase
      write_reg(CFG_LINE_SIZE, {2'b00, size_v});
      write_reg(CFG_LOWEST_KEY, lowest_v);
      write_reg(CFG_HIGHEST_KEY, highest_v);

      // Mostly typing and cursor work, some finishes, the rest noise
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r   = $urandom_range(0, 99);
        ext = 1'b0;
        if (r < 45) begin
          key_lo = (cfg_lowest > PRINT_LO) ? cfg_lowest : PRINT_LO;
          key_hi = (cfg_highest < PRINT_HI) ? cfg_highest : PRINT_HI;
          if (key_lo <= key_hi) key = 8'($urandom_range(key_hi, key_lo));
          else key = 8'($urandom_range(PRINT_HI, PRINT_LO));
        end else if (r < 67) begin
          ext = 1'b1;
          case ($urandom_range(0, 4))
            0:       key = KEY_LEFT;
            1:       key = KEY_RIGHT;
            2:       key = KEY_HOME;
            3:       key = KEY_END;
            default: key = KEY_DEL;
          endcase
        end else if (r < 77) begin
          key = KEY_BACK;
        end else if (r < 84) begin
          key = ($urandom_range(0, 1) == 1) ? KEY_ENTER : KEY_ESC;
        end else begin
          key = 8'($urandom_range(0, 255));
          ext = 1'($urandom_range(0, 1));
        end
        send_key(key, ext, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/leb_pkg.sv
hdl/leb_ram.sv
hdl/leb_ctrl.sv
hdl/leb_dp.sv
hdl/line_edit_buffer.sv
tb/line_edit_buffer_test.sv
